>>> rtl/core/ifmt_pkg.sv
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types, codes and character helpers for the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ifmt_pkg;

  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned CharW    = 8;
  localparam int unsigned DecBits  = 32;
  localparam int unsigned DecDigits = 10;
  localparam int unsigned HexDigits = 16;
  localparam int unsigned CntW     = 5;
  localparam int unsigned TxtW     = 3;

  // request types
  localparam logic [ReqTypeW-1:0] REQ_SDEC = 3'd0;
  localparam logic [ReqTypeW-1:0] REQ_UDEC = 3'd1;
  localparam logic [ReqTypeW-1:0] REQ_HEXL = 3'd2;
  localparam logic [ReqTypeW-1:0] REQ_HEXU = 3'd3;
  localparam logic [ReqTypeW-1:0] REQ_PTR  = 3'd4;

  // fixed text: "0x", "(nil)", "-"
  localparam logic [TxtW-1:0] TXT_ZERO     = 3'd0;
  localparam logic [TxtW-1:0] TXT_X        = 3'd1;
  localparam logic [TxtW-1:0] TXT_NIL_OPEN = 3'd2;
  localparam logic [TxtW-1:0] TXT_NIL_N    = 3'd3;
  localparam logic [TxtW-1:0] TXT_NIL_I    = 3'd4;
  localparam logic [TxtW-1:0] TXT_NIL_L    = 3'd5;
  localparam logic [TxtW-1:0] TXT_NIL_CLS  = 3'd6;
  localparam logic [TxtW-1:0] TXT_MINUS    = 3'd7;

  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_LA    = 8'h61;
  localparam logic [CharW-1:0] CH_UA    = 8'h41;

  typedef enum logic {
    EMIT_TEXT,
    EMIT_DIGIT
  } emit_sel_e;

  typedef struct packed {
    logic            load;
    logic            dabble;
    logic            shift;
    logic            emit;
    emit_sel_e       emit_sel;
    logic [TxtW-1:0] txt_idx;
    logic            emit_last;
  } ifmt_cmd_t;

  typedef struct packed {
    logic            out_free;
    logic            top_zero;
    logic            one_left;
    logic            neg;
    logic            is_ptr;
  } ifmt_sts_t;

  function automatic logic [CharW-1:0] text_char(logic [TxtW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      TXT_ZERO:     c = 8'h30;
      TXT_X:        c = 8'h78;
      TXT_NIL_OPEN: c = 8'h28;
      TXT_NIL_N:    c = 8'h6E;
      TXT_NIL_I:    c = 8'h69;
      TXT_NIL_L:    c = 8'h6C;
      TXT_NIL_CLS:  c = 8'h29;
      TXT_MINUS:    c = 8'h2D;
      default:      c = 8'h30;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] digit_char(logic [3:0] d, logic upper);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      c = CH_UA + {4'd0, d} - 8'd10;
    end else begin
      c = CH_LA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one integer request as a stream of ASCII characters.
// ----------------------------------------------------------------------------
// One request at a time. Decimal modes first run a bit-serial BCD conversion
// of the low 32 bits, hex and pointer modes none; then up to 9 (decimal) or 15
// (hex) leading zero digits are dropped one nibble per cycle, the prefix is
// picked, and characters leave one per cycle through a registered output
// while the output is not stalled.
// Undefined request types are accepted and produce no characters.
`default_nettype none

module integer_to_ascii_formatter_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [ifmt_pkg::ValueW-1:0]   s_axis_tdata,   // [63:0] value
  input  wire logic [ifmt_pkg::ReqTypeW-1:0] s_axis_tuser,   // [2:0] req_type
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [ifmt_pkg::CharW-1:0]    m_axis_tdata,   // [7:0] char_code
  output      logic                          m_axis_tlast    // last_char
);
  import ifmt_pkg::*;

  ifmt_cmd_t cmd;
  ifmt_sts_t sts;
  logic      value_zero;

  assign value_zero = (s_axis_tdata == '0);

  ifmt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .value_zero_i (value_zero),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  ifmt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_type_i  (s_axis_tuser),
    .value_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/core/ifmt_datapath.sv
// ----------------------------------------------------------------------------
// ifmt_datapath
// Digit register with double-dabble conversion, leading-zero shift,
// character selection and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ifmt_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [ifmt_pkg::ReqTypeW-1:0] req_type_i,
  input  wire logic [ifmt_pkg::ValueW-1:0]   value_i,
  input  wire ifmt_pkg::ifmt_cmd_t           cmd_i,
  output      ifmt_pkg::ifmt_sts_t           sts_o,
  input  wire logic                          out_ready_i,
  output      logic                          out_valid_o,
  output      logic [ifmt_pkg::CharW-1:0]    out_char_o,
  output      logic                          out_last_o
);
  import ifmt_pkg::*;

  localparam int unsigned BcdW = 4 * DecDigits;

  logic [ValueW-1:0]  dig_q, dig_d;
  logic [DecBits-1:0] bin_q, bin_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic               ptr_q, ptr_d;
  logic               upper_q, upper_d;
  logic               out_valid_q, out_valid_d;
  logic [CharW-1:0]   out_char_q, out_char_d;
  logic               out_last_q, out_last_d;

  logic [DecBits-1:0] lo;
  logic [BcdW-1:0]    bcd_adj;
  logic               out_free;

  assign lo       = value_i[DecBits-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (dig_q[ValueW-BcdW+4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = dig_q[ValueW-BcdW+4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = dig_q[ValueW-BcdW+4*i +: 4];
      end
    end
  end

  always_comb begin
    dig_d   = dig_q;
    bin_d   = bin_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    ptr_d   = ptr_q;
    upper_d = upper_q;
    if (cmd_i.load) begin
      neg_d   = (req_type_i == REQ_SDEC) && lo[DecBits-1];
      ptr_d   = (req_type_i == REQ_PTR);
      upper_d = (req_type_i == REQ_HEXU);
      if ((req_type_i == REQ_SDEC) || (req_type_i == REQ_UDEC)) begin
        dig_d = '0;
        cnt_d = CntW'(DecDigits);
        if ((req_type_i == REQ_SDEC) && lo[DecBits-1]) begin
          bin_d = DecBits'(0) - lo;
        end else begin
          bin_d = lo;
        end
      end else begin
        dig_d = value_i;
        cnt_d = CntW'(HexDigits);
      end
    end else if (cmd_i.dabble) begin
      dig_d = {bcd_adj[BcdW-2:0], bin_q[DecBits-1], {(ValueW-BcdW){1'b0}}};
      bin_d = {bin_q[DecBits-2:0], 1'b0};
    end else if (cmd_i.shift) begin
      dig_d = {dig_q[ValueW-5:0], 4'd0};
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_last_d  = cmd_i.emit_last;
      unique case (cmd_i.emit_sel)
        EMIT_TEXT:  out_char_d = text_char(cmd_i.txt_idx);
        EMIT_DIGIT: out_char_d = digit_char(dig_q[ValueW-1 -: 4], upper_q);
        default:    out_char_d = text_char(cmd_i.txt_idx);
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q      <= dig_d;
    bin_q      <= bin_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    ptr_q      <= ptr_d;
    upper_q    <= upper_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.out_free = out_free;
  assign sts_o.top_zero = (dig_q[ValueW-1 -: 4] == 4'd0);
  assign sts_o.one_left = (cnt_q == CntW'(1));
  assign sts_o.neg      = neg_q;
  assign sts_o.is_ptr   = ptr_q;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/ifmt_ctrl.sv
// ----------------------------------------------------------------------------
// ifmt_ctrl
// Sequencer: accepts a request, runs the conversion, drops leading zeros,
// then steps through prefix text and digits.
// ----------------------------------------------------------------------------
`default_nettype none

module ifmt_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [ifmt_pkg::ReqTypeW-1:0] req_type_i,
  input  wire logic                          value_zero_i,
  input  wire ifmt_pkg::ifmt_sts_t           sts_i,
  output      ifmt_pkg::ifmt_cmd_t           cmd_o
);
  import ifmt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_PFX  = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] step_q, step_d;
  logic [TxtW-1:0] txt_q, txt_d;

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    txt_d         = txt_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.emit_sel = EMIT_TEXT;
    cmd_o.txt_idx = txt_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          priority if ((req_type_i == REQ_SDEC) || (req_type_i == REQ_UDEC)) begin
            state_d = S_CONV;
          end else if ((req_type_i == REQ_HEXL) || (req_type_i == REQ_HEXU)) begin
            state_d = S_SKIP;
          end else if (req_type_i == REQ_PTR) begin
            if (value_zero_i) begin
              state_d = S_PFX;
              txt_d   = TXT_NIL_OPEN;
            end else begin
              state_d = S_SKIP;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CONV: begin
        cmd_o.dabble = 1'b1;
        step_d       = step_q + CntW'(1);
        if (step_q == CntW'(DecBits - 1)) begin
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (sts_i.top_zero && !sts_i.one_left) begin
          cmd_o.shift = 1'b1;
        end else if (sts_i.neg) begin
          state_d = S_PFX;
          txt_d   = TXT_MINUS;
        end else if (sts_i.is_ptr) begin
          state_d = S_PFX;
          txt_d   = TXT_ZERO;
        end else begin
          state_d = S_DIG;
        end
      end
      S_PFX: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = (txt_q == TXT_NIL_CLS);
          priority if ((txt_q == TXT_MINUS) || (txt_q == TXT_X)) begin
            state_d = S_DIG;
          end else if (txt_q == TXT_NIL_CLS) begin
            state_d = S_IDLE;
          end else begin
            txt_d = txt_q + TxtW'(1);
          end
        end
      end
      S_DIG: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_DIGIT;
          cmd_o.shift     = 1'b1;
          cmd_o.emit_last = sts_i.one_left;
          if (sts_i.one_left) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    txt_q  <= txt_d;
  end

endmodule

`default_nettype wire
